// ===== rtl/szpc_pkg.sv =====
package szpc_pkg;

  // point and trig precision
  localparam int COORD_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  // register field widths
  localparam int SEL_W  = 3;
  localparam int RAD_W  = 15;
  localparam int LEN_W  = 16;
  localparam int CFG_DW = 16;
  localparam int IDX_W  = 3;
  localparam int SQR_W  = 2 * RAD_W;

  // pentagon coordinate width: scaled point or vertex differences, signed
  localparam int PMAG = (COORD_BITS - 1 > RAD_W) ? COORD_BITS - 1 : RAD_W;
  localparam int PW   = PMAG + TRIG_FRAC_BITS + 2;

  // triangle linear terms and products
  localparam int TW  = ((COORD_BITS > LEN_W) ? COORD_BITS : LEN_W) + 3;
  localparam int TPW = 2 * TW;

  // circle, square and ellipse compare widths
  localparam int CMPW = (2 * COORD_BITS + 1 > SQR_W) ? 2 * COORD_BITS + 1 : SQR_W;
  localparam int QW   = (COORD_BITS + 1 > LEN_W) ? COORD_BITS + 1 : LEN_W;
  localparam int EPW  = COORD_BITS + SQR_W;
  localparam int EW   = 2 * COORD_BITS + SQR_W + 2;

  // sine and cosine constants in Q2.30, rounded half up to the trig precision
  localparam longint COS1_Q30 = 64'sd1021189158;
  localparam longint SIN1_Q30 = 64'sd331804471;
  localparam longint COS3_Q30 = 64'sd631129609;
  localparam longint SIN3_Q30 = 64'sd868675383;
  localparam int     TRIG_SH  = 30 - TRIG_FRAC_BITS;
  localparam longint TRIG_HALF = 64'sd1 <<< (TRIG_SH - 1);

  localparam logic [TRIG_FRAC_BITS:0] TRIG_C1 =
    (TRIG_FRAC_BITS + 1)'((COS1_Q30 + TRIG_HALF) >>> TRIG_SH);
  localparam logic [TRIG_FRAC_BITS:0] TRIG_S1 =
    (TRIG_FRAC_BITS + 1)'((SIN1_Q30 + TRIG_HALF) >>> TRIG_SH);
  localparam logic [TRIG_FRAC_BITS:0] TRIG_C3 =
    (TRIG_FRAC_BITS + 1)'((COS3_Q30 + TRIG_HALF) >>> TRIG_SH);
  localparam logic [TRIG_FRAC_BITS:0] TRIG_S3 =
    (TRIG_FRAC_BITS + 1)'((SIN3_Q30 + TRIG_HALF) >>> TRIG_SH);

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SHAPE    = 3'd0,
    REG_CIRC_R   = 3'd1,
    REG_TRI_H    = 3'd2,
    REG_TRI_B    = 3'd3,
    REG_SQ_SIDE  = 3'd4,
    REG_ELL_MAJ  = 3'd5,
    REG_ELL_MIN  = 3'd6,
    REG_PENT_R   = 3'd7
  } cfg_idx_t;

  // shape codes, anything above ellipse is pentagon
  localparam logic [SEL_W-1:0] SHAPE_TRI  = 3'd0;
  localparam logic [SEL_W-1:0] SHAPE_CIRC = 3'd1;
  localparam logic [SEL_W-1:0] SHAPE_SQ   = 3'd2;
  localparam logic [SEL_W-1:0] SHAPE_ELL  = 3'd3;

  // zone settings and values derived from them
  typedef struct packed {
    logic [SEL_W-1:0]    shape;
    logic [LEN_W-1:0]    tri_h;
    logic [LEN_W-1:0]    tri_b;
    logic [LEN_W-1:0]    sq_side;
    logic [SQR_W-1:0]    circ_r2;
    logic [SQR_W-1:0]    ell_a2;
    logic [SQR_W-1:0]    ell_m2;
    logic [2*SQR_W-1:0]  ell_ma;
    logic signed [PW-1:0] pent_top;
    logic signed [PW-1:0] pent_c1;
    logic signed [PW-1:0] pent_s1;
    logic signed [PW-1:0] pent_c3;
    logic signed [PW-1:0] pent_s3;
  } cfg_t;

  // per-stage advance for the edge units
  typedef struct packed {
    logic s2;
    logic s3;
  } stg_en_t;

endpackage

// ===== rtl/szpc_cfg.sv =====
module szpc_cfg
  import szpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  logic [SEL_W-1:0] shape_r;
  logic [RAD_W-1:0] circ_r_r;
  logic [LEN_W-1:0] tri_h_r;
  logic [LEN_W-1:0] tri_b_r;
  logic [LEN_W-1:0] sq_side_r;
  logic [RAD_W-1:0] ell_a_r;
  logic [RAD_W-1:0] ell_m_r;
  logic [RAD_W-1:0] pent_l_r;

  logic [SQR_W-1:0]     circ_r2_r;
  logic [SQR_W-1:0]     ell_a2_r;
  logic [SQR_W-1:0]     ell_m2_r;
  logic [2*SQR_W-1:0]   ell_ma_r;
  logic signed [PW-1:0] pent_top_r;
  logic signed [PW-1:0] pent_c1_r;
  logic signed [PW-1:0] pent_s1_r;
  logic signed [PW-1:0] pent_c3_r;
  logic signed [PW-1:0] pent_s3_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r   <= 3'd1;
      circ_r_r  <= 15'd1000;
      tri_h_r   <= 16'd2000;
      tri_b_r   <= 16'd2000;
      sq_side_r <= 16'd2000;
      ell_a_r   <= 15'd1500;
      ell_m_r   <= 15'd1000;
      pent_l_r  <= 15'd1000;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_SHAPE:   shape_r   <= cfg_wdata[SEL_W-1:0];
        REG_CIRC_R:  circ_r_r  <= cfg_wdata[RAD_W-1:0];
        REG_TRI_H:   tri_h_r   <= cfg_wdata[LEN_W-1:0];
        REG_TRI_B:   tri_b_r   <= cfg_wdata[LEN_W-1:0];
        REG_SQ_SIDE: sq_side_r <= cfg_wdata[LEN_W-1:0];
        REG_ELL_MAJ: ell_a_r   <= cfg_wdata[RAD_W-1:0];
        REG_ELL_MIN: ell_m_r   <= cfg_wdata[RAD_W-1:0];
        REG_PENT_R:  pent_l_r  <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // derived squares and pentagon vertex terms, registered from the settings
  always_ff @(posedge clk) begin
    circ_r2_r  <= SQR_W'(circ_r_r) * SQR_W'(circ_r_r);
    ell_a2_r   <= SQR_W'(ell_a_r) * SQR_W'(ell_a_r);
    ell_m2_r   <= SQR_W'(ell_m_r) * SQR_W'(ell_m_r);
    ell_ma_r   <= (2*SQR_W)'(ell_a2_r) * (2*SQR_W)'(ell_m2_r);
    pent_top_r <= $signed(PW'(pent_l_r) << TRIG_FRAC_BITS);
    pent_c1_r  <= $signed(PW'(pent_l_r) * PW'(TRIG_C1));
    pent_s1_r  <= $signed(PW'(pent_l_r) * PW'(TRIG_S1));
    pent_c3_r  <= $signed(PW'(pent_l_r) * PW'(TRIG_C3));
    pent_s3_r  <= $signed(PW'(pent_l_r) * PW'(TRIG_S3));
  end

  always_comb begin
    cfg.shape    = shape_r;
    cfg.tri_h    = tri_h_r;
    cfg.tri_b    = tri_b_r;
    cfg.sq_side  = sq_side_r;
    cfg.circ_r2  = circ_r2_r;
    cfg.ell_a2   = ell_a2_r;
    cfg.ell_m2   = ell_m2_r;
    cfg.ell_ma   = ell_ma_r;
    cfg.pent_top = pent_top_r;
    cfg.pent_c1  = pent_c1_r;
    cfg.pent_s1  = pent_s1_r;
    cfg.pent_c3  = pent_c3_r;
    cfg.pent_s3  = pent_s3_r;
  end

endmodule

// ===== rtl/szpc_edge.sv =====
module szpc_edge
  import szpc_pkg::*;
(
  input  logic                 clk,
  input  stg_en_t              en,
  input  logic signed [PW-1:0] px,
  input  logic signed [PW-1:0] py,
  input  logic signed [PW-1:0] xi,
  input  logic signed [PW-1:0] yi,
  input  logic signed [PW-1:0] xj,
  input  logic signed [PW-1:0] yj,
  output logic                 on_edge,
  output logic                 toggle
);

  logic signed [PW-1:0] dpx_r, dpy_r, dx_r, dy_r;
  logic                 strad2_r, box2_r;
  logic signed [2*PW-1:0] pa_r, pb_r;
  logic                 strad3_r, box3_r, dyp_r, dyn_r;
  logic signed [2*PW:0] cr;
  logic                 cr_zero, cr_pos, cr_neg;
  logic                 in_x, in_y;

  // bounding box of the edge
  always_comb begin
    in_x = (xi < xj) ? (px >= xi && px <= xj) : (px >= xj && px <= xi);
    in_y = (yi < yj) ? (py >= yi && py <= yj) : (py >= yj && py <= yi);
  end

  // stage 2: differences, straddle and box flags
  always_ff @(posedge clk) begin
    if (en.s2) begin
      dpx_r    <= px - xi;
      dpy_r    <= py - yi;
      dx_r     <= xj - xi;
      dy_r     <= yj - yi;
      strad2_r <= (yi > py) != (yj > py);
      box2_r   <= in_x && in_y;
    end
  end

  // stage 3: the two cross products
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pa_r     <= dx_r * dpy_r;
      pb_r     <= dy_r * dpx_r;
      strad3_r <= strad2_r;
      box3_r   <= box2_r;
      dyp_r    <= dy_r > 0;
      dyn_r    <= dy_r[PW-1];
    end
  end

  // side of the edge and crossing decision
  always_comb begin
    cr      = (2*PW+1)'(pa_r) - (2*PW+1)'(pb_r);
    cr_zero = (cr == '0);
    cr_neg  = cr[2*PW];
    cr_pos  = !cr_neg && !cr_zero;
    on_edge = box3_r && cr_zero;
    toggle  = strad3_r && ((dyp_r && cr_pos) || (dyn_r && cr_neg));
  end

endmodule

// ===== rtl/safety_zone_point_classifier_top.sv =====
// channel  | ports                                     | beat
// ---------+-------------------------------------------+---------------------------
// in       | in_valid, in_stall, in_point_x/y          | one point, signed mm
// out      | out_valid, out_stall, out_inside_res      | one inside flag per point
// cfg      | cfg_wr_en, cfg_index, cfg_wdata           | one register write
//
// one point per cycle sustained while out_stall stays low; result registered through
// four register stages (input, squares/products, wide products, sums and result)
// each stage holds its beat only while the next is full and cannot advance, so bubbles close up
// rst_n is synchronous; setting registers take their reset values, pipeline empties
// a zone write reaches the derived squares and vertices through the setting and derived registers
module safety_zone_point_classifier_top
  import szpc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  input  logic                         cfg_wr_en,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CFG_DW-1:0]            cfg_wdata
);

  cfg_t    cfg;
  stg_en_t edge_en;

  logic v1_r, v2_r, v3_r, out_valid_r, inside_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [COORD_BITS-1:0] x1_r, y1_r;
  logic [COORD_BITS-1:0] xr, yr, ax, ay;
  logic signed [PW-1:0] px, py;
  logic signed [PW-1:0] vx [5];
  logic signed [PW-1:0] vy [5];
  logic [4:0] on_e, tog_e;

  logic signed [TW-1:0] us, vs, hs, bs, t_a, t_b, t_c;
  logic [2*COORD_BITS-1:0] ax2_r, ay2_r;
  logic sq2_r, sq3_r, circ3_r, tri3_r;
  logic signed [TPW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [TPW+2:0] s1, s2, s3;
  logic n1, n2, n3, q1, q2, q3;
  logic [EPW-1:0] exh_r, exl_r, eyh_r, eyl_r;
  logic [EW-1:0] ell_lhs;
  logic ell_in, pent_in, inside_nxt;

  szpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage advance, each stage moves when its successor frees up
  always_comb begin
    rdy4     = !out_valid_r || !out_stall;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    in_stall = !rdy1 || !rst_n;
    edge_en.s2 = rdy2;
    edge_en.s3 = rdy3;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r <= in_point_x;
      y1_r <= in_point_y;
    end
  end

  // magnitudes and triangle terms (triangle uses u = y, v = x)
  always_comb begin
    xr  = x1_r;
    yr  = y1_r;
    ax  = xr[COORD_BITS-1] ? (~xr + COORD_BITS'(1)) : xr;
    ay  = yr[COORD_BITS-1] ? (~yr + COORD_BITS'(1)) : yr;
    us  = TW'(y1_r);
    vs  = TW'(x1_r);
    hs  = $signed(TW'(cfg.tri_h));
    bs  = $signed(TW'(cfg.tri_b));
    t_a = (vs <<< 1) - hs;
    t_b = (vs <<< 1) + hs;
    t_c = (us <<< 1) - bs;
  end

  // pentagon point scaled to the trig precision, vertices in (u, v)
  always_comb begin
    px    = PW'(y1_r) <<< TRIG_FRAC_BITS;
    py    = PW'(x1_r) <<< TRIG_FRAC_BITS;
    vx[0] = '0;           vy[0] = cfg.pent_top;
    vx[1] = -cfg.pent_c1; vy[1] = cfg.pent_s1;
    vx[2] = -cfg.pent_c3; vy[2] = -cfg.pent_s3;
    vx[3] = cfg.pent_c3;  vy[3] = -cfg.pent_s3;
    vx[4] = cfg.pent_c1;  vy[4] = cfg.pent_s1;
  end

  // stage 2: squares, square bounds, triangle products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      ax2_r <= (2*COORD_BITS)'(ax) * (2*COORD_BITS)'(ax);
      ay2_r <= (2*COORD_BITS)'(ay) * (2*COORD_BITS)'(ay);
      sq2_r <= (QW'({ax, 1'b0}) <= QW'(cfg.sq_side)) &&
               (QW'({ay, 1'b0}) <= QW'(cfg.sq_side));
      p1_r  <= us * hs;
      p2_r  <= bs * t_a;
      p3_r  <= bs * t_b;
      p4_r  <= hs * t_c;
    end
  end

  // triangle edge signs
  always_comb begin
    s1 = -((TPW+3)'(p1_r) <<< 2) + (TPW+3)'(p2_r);
    s2 = -((TPW+3)'(p3_r) <<< 1);
    s3 = ((TPW+3)'(p4_r) <<< 1) + (TPW+3)'(p3_r);
    n1 = s1[TPW+2];
    n2 = s2[TPW+2];
    n3 = s3[TPW+2];
    q1 = !n1 && (s1 != '0);
    q2 = !n2 && (s2 != '0);
    q3 = !n3 && (s3 != '0);
  end

  // stage 3: circle and triangle decisions, ellipse partial products
  always_ff @(posedge clk) begin
    if (rdy3) begin
      circ3_r <= (CMPW'(ax2_r) + CMPW'(ay2_r)) <= CMPW'(cfg.circ_r2);
      tri3_r  <= (!n1 && !n2 && !n3) || (!q1 && !q2 && !q3);
      sq3_r   <= sq2_r;
      exh_r   <= EPW'(ax2_r[2*COORD_BITS-1:COORD_BITS]) * EPW'(cfg.ell_a2);
      exl_r   <= EPW'(ax2_r[COORD_BITS-1:0]) * EPW'(cfg.ell_a2);
      eyh_r   <= EPW'(ay2_r[2*COORD_BITS-1:COORD_BITS]) * EPW'(cfg.ell_m2);
      eyl_r   <= EPW'(ay2_r[COORD_BITS-1:0]) * EPW'(cfg.ell_m2);
    end
  end

  // pentagon edges
  for (genvar i = 0; i < 5; i++) begin : g_edge
    szpc_edge u_edge (
      .clk     (clk),
      .en      (edge_en),
      .px      (px),
      .py      (py),
      .xi      (vx[i]),
      .yi      (vy[i]),
      .xj      (vx[(i + 1) % 5]),
      .yj      (vy[(i + 1) % 5]),
      .on_edge (on_e[i]),
      .toggle  (tog_e[i])
    );
  end

  // ellipse sum, pentagon parity and shape select
  always_comb begin
    ell_lhs = (EW'(exh_r) << COORD_BITS) + EW'(exl_r) +
              (EW'(eyh_r) << COORD_BITS) + EW'(eyl_r);
    ell_in  = ell_lhs <= EW'(cfg.ell_ma);
    pent_in = (|on_e) || (^tog_e);
    unique case (cfg.shape)
      SHAPE_TRI:  inside_nxt = tri3_r;
      SHAPE_CIRC: inside_nxt = circ3_r;
      SHAPE_SQ:   inside_nxt = sq3_r;
      SHAPE_ELL:  inside_nxt = ell_in;
      default:    inside_nxt = pent_in;
    endcase
  end

  // stage 4: result register
  always_ff @(posedge clk) begin
    if (rdy4) inside_r <= inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

  // input held off only when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a free stage");

  // a waiting last-stage beat is not dropped while the output is held
  a_hold_v3: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_valid_r && out_stall) |=> v3_r)
    else $error("stage 3 beat lost under output stall");

  // a result appears only behind a full stage 3
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result without a stage 3 beat");

endmodule

// ===== tb/safety_zone_point_classifier_top_test.sv =====
`timescale 1ns / 100ps

module safety_zone_point_classifier_top_test;
  import szpc_pkg::*;

  typedef logic signed [127:0] wint_t;
  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_inside_res;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // zone settings as the block should hold them
  logic [SEL_W-1:0] zn_shape = 3'd1;
  logic [RAD_W-1:0] zn_circ_r = 15'd1000;
  logic [LEN_W-1:0] zn_tri_h = 16'd2000;
  logic [LEN_W-1:0] zn_tri_b = 16'd2000;
  logic [LEN_W-1:0] zn_sq_side = 16'd2000;
  logic [RAD_W-1:0] zn_ell_a = 15'd1500;
  logic [RAD_W-1:0] zn_ell_m = 15'd1000;
  logic [RAD_W-1:0] zn_pent_r = 15'd1000;

  point_t point_q[$];
  logic   inside_q[$];
  int     fails = 0;
  bit     no_idle = 1'b0;
  int     in_gap = 0;
  int     out_hold = 0;
  int     quiet_cycles = 0;

  safety_zone_point_classifier_top dut (.*);

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int sgn(wint_t v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  function automatic wint_t trig_fix(longint q30);
    return (q30 + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
  endfunction

  function automatic int wait_draw();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // pentagon by even-odd ray casting, edge points inside
  function automatic logic pent_hit(wint_t u, wint_t v);
    wint_t lr, one, px, py, xi, yi, xj, yj, dy;
    wint_t vx[5], vy[5];
    logic odd;
    int j, k;
    lr = zn_pent_r;
    one = wint_t'(1) <<< TRIG_FRAC_BITS;
    px = u * one;
    py = v * one;
    odd = 1'b0;
    vx[0] = 0;                       vy[0] = lr * one;
    vx[1] = -lr * trig_fix(COS1_Q30); vy[1] = lr * trig_fix(SIN1_Q30);
    vx[2] = -lr * trig_fix(COS3_Q30); vy[2] = -lr * trig_fix(SIN3_Q30);
    vx[3] = lr * trig_fix(COS3_Q30);  vy[3] = -lr * trig_fix(SIN3_Q30);
    vx[4] = lr * trig_fix(COS1_Q30);  vy[4] = lr * trig_fix(SIN1_Q30);
    for (int i = 0; i < 5; i++) begin
      j = (i + 1) % 5;
      xi = vx[i]; yi = vy[i]; xj = vx[j]; yj = vy[j];
      if ((xj - xi) * (py - yi) == (yj - yi) * (px - xi) &&
          px >= ((xi < xj) ? xi : xj) && px <= ((xi < xj) ? xj : xi) &&
          py >= ((yi < yj) ? yi : yj) && py <= ((yi < yj) ? yj : yi))
        return 1'b1;
      if ((yi > py) != (yj > py)) begin
        dy = yj - yi;
        k = sgn((px - xi) * dy - (py - yi) * (xj - xi));
        if ((dy > 0 && k < 0) || (dy < 0 && k > 0)) odd = ~odd;
      end
    end
    return odd;
  endfunction

  // inside flag for one point under the current zone
  function automatic logic zone_hit(logic signed [COORD_BITS-1:0] px_in,
                                    logic signed [COORD_BITS-1:0] py_in);
    wint_t x, y, h, b, tx, ty, a2, m2;
    int s1, s2, s3;
    x = px_in;
    y = py_in;
    case (zn_shape)
      SHAPE_TRI: begin
        h = zn_tri_h;
        b = zn_tri_b;
        // swapped and doubled coordinates
        tx = 2 * y;
        ty = 2 * x;
        s1 = sgn(tx * (-2 * h) - (ty - h) * (-b));
        s2 = sgn(-(ty + h) * (2 * b));
        s3 = sgn((tx - b) * (2 * h) - (ty + h) * (-b));
        return (s1 >= 0 && s2 >= 0 && s3 >= 0) || (s1 <= 0 && s2 <= 0 && s3 <= 0);
      end
      SHAPE_CIRC: return x * x + y * y <= wint_t'(zn_circ_r) * wint_t'(zn_circ_r);
      SHAPE_SQ: begin
        tx = (x < 0) ? -x : x;
        ty = (y < 0) ? -y : y;
        return 2 * tx <= wint_t'(zn_sq_side) && 2 * ty <= wint_t'(zn_sq_side);
      end
      SHAPE_ELL: begin
        a2 = wint_t'(zn_ell_a) * wint_t'(zn_ell_a);
        m2 = wint_t'(zn_ell_m) * wint_t'(zn_ell_m);
        return x * x * a2 + y * y * m2 <= m2 * a2;
      end
      default: return pent_hit(y, x);
    endcase
  endfunction

  // input driver, predicts each accepted beat
  always @(posedge clk) begin
    point_t pt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) inside_q.push_back(zone_hit(in_point_x, in_point_y));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        pt = point_q.pop_front();
        in_point_x <= pt.x;
        in_point_y <= pt.y;
        in_valid <= 1'b1;
        in_gap <= wait_draw();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor with random stall
  always @(posedge clk) begin
    logic want;
    int n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else if (out_valid && !out_stall) begin
      if (inside_q.size() == 0) begin
        $error("unexpected result beat, inside_res=%0d", out_inside_res);
        fails++;
      end else begin
        want = inside_q.pop_front();
        if (out_inside_res !== want) begin
          $error("inside_res mismatch: expected %0d actual %0d", want, out_inside_res);
          fails++;
        end
      end
      n = wait_draw();
      out_stall <= (n != 0);
      out_hold <= n;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_stall <= (out_hold > 1);
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk) begin
    if (rst_n && (point_q.size() > 0 || inside_q.size() > 0 || in_valid) &&
        !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    case (idx)
      REG_SHAPE:   zn_shape = val[SEL_W-1:0];
      REG_CIRC_R:  zn_circ_r = val[RAD_W-1:0];
      REG_TRI_H:   zn_tri_h = val[LEN_W-1:0];
      REG_TRI_B:   zn_tri_b = val[LEN_W-1:0];
      REG_SQ_SIDE: zn_sq_side = val[LEN_W-1:0];
      REG_ELL_MAJ: zn_ell_a = val[RAD_W-1:0];
      REG_ELL_MIN: zn_ell_m = val[RAD_W-1:0];
      default:     zn_pent_r = val[RAD_W-1:0];
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  task automatic wait_idle();
    while (point_q.size() > 0 || inside_q.size() > 0 || in_valid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_point(int x, int y);
    point_t pt;
    pt.x = x[COORD_BITS-1:0];
    pt.y = y[COORD_BITS-1:0];
    point_q.push_back(pt);
  endtask

  function automatic int rand_len(int maxv);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return maxv;
      2: return $urandom_range(0, maxv);
      default: return $urandom_range(1, 4000);
    endcase
  endfunction

  function automatic int rand_coord(int span);
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 65535) - 32768;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // stimulus
  initial begin
    int span;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // directed: reset zone, then every shape with extremes and boundary points
    add_point(0, 0);
    add_point(1000, 0);
    add_point(707, 708);
    add_point(-32768, -32768);
    add_point(32767, 32767);
    wait_idle();
    for (int s = 0; s <= 7; s++) begin
      if (s == 5 || s == 6) continue;
      write_reg(REG_SHAPE, s);
      end_writes();
      add_point(0, 0);
      add_point(32767, -32768);
      add_point(0, 1000);
      wait_idle();
    end

    // random zones, extremes included
    for (int ph = 0; ph < 40; ph++) begin
      write_reg(REG_SHAPE, $urandom_range(0, 7));
      write_reg(REG_CIRC_R, rand_len(32767));
      write_reg(REG_TRI_H, rand_len(65535));
      write_reg(REG_TRI_B, rand_len(65535));
      write_reg(REG_SQ_SIDE, rand_len(65535));
      write_reg(REG_ELL_MAJ, rand_len(32767));
      write_reg(REG_ELL_MIN, rand_len(32767));
      write_reg(REG_PENT_R, rand_len(32767));
      end_writes();
      no_idle = ($urandom_range(0, 4) == 0);
      case (zn_shape)
        SHAPE_TRI:  span = (zn_tri_h > zn_tri_b) ? zn_tri_h : zn_tri_b;
        SHAPE_CIRC: span = zn_circ_r;
        SHAPE_SQ:   span = zn_sq_side / 2;
        SHAPE_ELL:  span = (zn_ell_a > zn_ell_m) ? zn_ell_a : zn_ell_m;
        default:    span = zn_pent_r;
      endcase
      span = span + span / 4 + 2;
      if (span > 32767) span = 32767;
      for (int i = 0; i < 48; i++) add_point(rand_coord(span), rand_coord(span));
      wait_idle();
    end

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
